// File: design/ssfl_pkg.sv
package ssfl_pkg;

  // Search limits
  localparam int PatternMax = 16;
  localparam int WindowDepth = 16;
  localparam longint unsigned TextMax = 64'd65536;
  localparam int CountW = $clog2(TextMax + 64'd1);
  localparam int LenW = 5;
  localparam int PosW = 16;
  localparam longint unsigned PosMax = (64'd1 << PosW) - 64'd1;

  // Configuration register map
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 64;
  localparam logic [CfgIdxW-1:0] CfgPatternLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPatternLen  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgFindLast    = 2'd3;

  typedef logic [WindowDepth-1:0][7:0] ssfl_window_t;
  typedef logic [PatternMax-1:0][7:0] ssfl_pattern_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } ssfl_in_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
    logic            too_long;
  } ssfl_out_t;

endpackage

// File: design/ssfl_window_match.sv
module ssfl_window_match (
  input  ssfl_pkg::ssfl_window_t  window_i,
  input  ssfl_pkg::ssfl_pattern_t pattern_i,
  input  logic [ssfl_pkg::LenW-1:0] len_i,
  output logic                      hit_o
);
  import ssfl_pkg::*;

  localparam int IdxW = $clog2(WindowDepth);

  logic [PatternMax-1:0] byte_ok;

  // Pattern byte j sits len-1-j places behind the newest byte.
  always_comb begin
    for (int j = 0; j < PatternMax; j++) begin
      byte_ok[j] = (LenW'(j) >= len_i) ||
                   (window_i[IdxW'(len_i - LenW'(1) - LenW'(j))] == pattern_i[j]);
    end
  end

  assign hit_o = &byte_ok;

endmodule

// File: design/substring_search_first_last_core.sv
// Streaming substring search, first or last occurrence.
//
// Input channel: one text byte per beat (in_valid_i / in_stall_o), with end_of_text
// marking the final byte of a text. Output channel: one result beat (found, position,
// too_long) per text, given after its final byte. Configuration: pattern bytes,
// pattern length and first/last mode are written through cfg_we_i / cfg_index_i /
// cfg_data_i. The user must write them only while the block is idle; it does not check.
//
// A byte accepted into the input register is compared there, and the result of a
// final byte is loaded into the result register, which drives out_valid_o.
// Throughput: one byte per cycle unless a final byte is held; the window compare of
// sixteen byte comparators between the input register and the search state
// sets this. Non-final bytes keep flowing while a result waits; a final byte
// waits in the input register only while the result register is full and stalled.
//
// Reset clears the search state, the window and the registers (pattern zero,
// length one, first mode). After each final byte the per-text state clears.
module substring_search_first_last_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ssfl_pkg::ssfl_in_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ssfl_pkg::ssfl_out_t         out_data_o,
  input  logic                        cfg_we_i,
  input  logic [ssfl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ssfl_pkg::CfgDataW-1:0] cfg_data_i
);
  import ssfl_pkg::*;

  localparam int SumW = ((CountW > LenW) ? CountW : LenW) + 1;

  // Configuration registers
  logic [63:0]     pat_low_q, pat_high_q;
  logic [LenW-1:0] pat_len_q;
  logic            find_last_q;

  // Input register
  logic     s1_valid_q;
  ssfl_in_t s1_data_q;

  // Per-text search state
  ssfl_window_t      window_q, window_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] start_q, start_d;
  logic              seen_q, seen_d;
  logic              ovf_q, ovf_d;

  // Result register
  logic      out_valid_q;
  ssfl_out_t out_data_q, out_data_d;

  logic            s1_adv, in_acc, out_acc, in_range, count_ok, hit, take;
  logic [LenW-1:0] len_eff;
  ssfl_window_t    window_sh;
  logic [SumW-1:0] count_ext, len_ext;

  // Hold a final byte while the result register is full and stalled.
  assign s1_adv     = s1_valid_q && (!s1_data_q.end_of_text || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  // Clamp the pattern length to the usable range.
  always_comb begin
    priority if (pat_len_q == '0) begin
      len_eff = LenW'(1);
    end else if (pat_len_q > LenW'(PatternMax)) begin
      len_eff = LenW'(PatternMax);
    end else begin
      len_eff = pat_len_q;
    end
  end

  assign window_sh = {window_q[WindowDepth-2:0], s1_data_q.text_byte};

  ssfl_window_match u_match (
    .window_i  (window_sh),
    .pattern_i ({pat_high_q, pat_low_q}),
    .len_i     (len_eff),
    .hit_o     (hit)
  );

  assign count_ext = SumW'(count_q);
  assign len_ext   = SumW'(len_eff);
  assign in_range  = (count_q < CountW'(TextMax));
  assign count_ok  = !((count_ext + SumW'(1)) < len_ext);
  assign take      = hit && count_ok && (find_last_q || !seen_q);

  always_comb begin
    window_d = window_q;
    count_d  = count_q;
    start_d  = start_q;
    seen_d   = seen_q;
    ovf_d    = ovf_q;
    if (in_range) begin
      window_d = window_sh;
      count_d  = count_q + CountW'(1);
      if (take) begin
        start_d = CountW'(count_ext + SumW'(1) - len_ext);
        seen_d  = 1'b1;
      end
    end else begin
      // Freeze the index beyond the text limit.
      ovf_d = 1'b1;
    end

    out_data_d.found    = seen_d;
    out_data_d.too_long = ovf_d;
    priority if (!seen_d) begin
      out_data_d.position = '0;
    end else if (64'(start_d) > PosMax) begin
      out_data_d.position = '1;
    end else begin
      out_data_d.position = PosW'(start_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q   <= '0;
      pat_high_q  <= '0;
      pat_len_q   <= LenW'(1);
      find_last_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPatternLow:  pat_low_q   <= cfg_data_i;
        CfgPatternHigh: pat_high_q  <= cfg_data_i;
        CfgPatternLen:  pat_len_q   <= cfg_data_i[LenW-1:0];
        CfgFindLast:    find_last_q <= cfg_data_i[0];
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= in_data_i;
    end
  end

  // Search state: advance on each compared byte, clear after a final byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      count_q  <= '0;
      start_q  <= '0;
      seen_q   <= 1'b0;
      ovf_q    <= 1'b0;
    end else if (s1_adv) begin
      if (s1_data_q.end_of_text) begin
        window_q <= '0;
        count_q  <= '0;
        start_q  <= '0;
        seen_q   <= 1'b0;
        ovf_q    <= 1'b0;
      end else begin
        window_q <= window_d;
        count_q  <= count_d;
        start_q  <= start_d;
        seen_q   <= seen_d;
        ovf_q    <= ovf_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_data_q.end_of_text) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_data_q.end_of_text) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: sim/substring_search_first_last_core_test.sv
`timescale 1ns / 1ps

module substring_search_first_last_core_test;
  import ssfl_pkg::*;

  // Cycles without any beat or register write before the run is abandoned
  localparam int QuietLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ssfl_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ssfl_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CfgPatternLow;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  substring_search_first_last_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Text bytes waiting for the driver, and search results still owed by the block
  ssfl_in_t  text_beats[$];
  ssfl_out_t results_due[$];

  // Our copy of the registers, updated as each write lands
  ssfl_pattern_t pat_now = '0;
  logic [LenW-1:0] len_now = LenW'(1);
  bit last_now = 1'b0;

  // Per-text search state of the predictor (index 0 of the window is the newest byte)
  ssfl_window_t window = '0;
  longint unsigned text_count = 0;
  longint unsigned hit_start = 0;
  bit hit_seen = 1'b0;
  bit overran = 1'b0;

  int errors = 0;
  int bytes_queued = 0;
  int in_gap_max = 5;
  int out_gap_max = 5;
  int in_wait = 0;
  int out_wait = 0;
  int quiet_cycles = 0;
  ssfl_out_t want;

  // Pattern length in force: zero counts as one, anything past the window saturates
  function automatic int eff_len();
    if (len_now == 0) return 1;
    if (len_now > PatternMax) return PatternMax;
    return int'(len_now);
  endfunction

  // Advance the search by one accepted byte; owe a result on the final byte of a text
  task absorb_byte(input ssfl_in_t beat);
    int n;
    bit hit;
    ssfl_out_t res;
    n = eff_len();
    if (text_count < TextMax) begin
      window = {window[WindowDepth-2:0], beat.text_byte};
      // no complete window until the text holds at least n bytes
      hit = (text_count + 1 >= longint'(n));
      for (int j = 0; j < n; j++) begin
        if (window[n-1-j] != pat_now[j]) hit = 1'b0;
      end
      if (hit && (last_now || !hit_seen)) begin
        hit_start = text_count + 1 - longint'(n);
        hit_seen = 1'b1;
      end
      text_count++;
    end else begin
      // past the text limit: drop the byte, keep the index frozen
      overran = 1'b1;
    end
    if (beat.end_of_text) begin
      res.found = hit_seen;
      if (!hit_seen) res.position = '0;
      else if (hit_start > PosMax) res.position = PosW'(PosMax);
      else res.position = PosW'(hit_start);
      res.too_long = overran;
      results_due.push_back(res);
      window = '0;
      text_count = 0;
      hit_start = 0;
      hit_seen = 1'b0;
      overran = 1'b0;
    end
  endtask

  // Driver: hold a stalled beat, otherwise wait out the drawn gap and present the next byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      in_wait = 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        absorb_byte(in_data_i);
        in_wait = $urandom_range(0, in_gap_max);
      end else if (in_wait > 0) begin
        in_wait--;
      end
      if (in_wait == 0 && text_beats.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= text_beats.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat against the oldest owed result, then draw a stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with none owed: found %0d position %0d too_long %0d",
                   $time, out_data_o.found, out_data_o.position, out_data_o.too_long);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (out_data_o.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found,
                     out_data_o.found);
            errors++;
          end
          if (out_data_o.position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position,
                     out_data_o.position);
            errors++;
          end
          if (out_data_o.too_long !== want.too_long) begin
            $display("%0t: too_long expected %0d actual %0d", $time, want.too_long,
                     out_data_o.too_long);
            errors++;
          end
        end
        out_wait = $urandom_range(0, out_gap_max);
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_stall_i <= (out_wait > 0);
    end
  end

  // Watchdog: abandon the run once nothing has moved for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: timeout, no beat for %0d cycles", $time, QuietLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task push_byte(input logic [7:0] b, input bit close);
    ssfl_in_t beat;
    beat.text_byte = b;
    beat.end_of_text = close;
    text_beats.push_back(beat);
    bytes_queued++;
  endtask

  // Wait until every byte is in and every result out, then let the pipeline go quiet
  task settle();
    do @(negedge clk_i);
    while (text_beats.size() != 0 || in_valid_i || results_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgPatternLow:  pat_now[7:0] = data;
      CfgPatternHigh: pat_now[15:8] = data;
      CfgPatternLen:  len_now = data[LenW-1:0];
      CfgFindLast:    last_now = data[0];
      default: ;
    endcase
  endtask

  // Write all four registers; spare bits of the narrow ones carry noise
  task set_pattern(input logic [63:0] lo, input logic [63:0] hi, input logic [LenW-1:0] len,
                   input bit last);
    logic [CfgDataW-1:0] junk;
    write_reg(CfgPatternLow, lo);
    write_reg(CfgPatternHigh, hi);
    junk = {$urandom(), $urandom()};
    junk[LenW-1:0] = len;
    write_reg(CfgPatternLen, junk);
    junk = {$urandom(), $urandom()};
    junk[0] = last;
    write_reg(CfgFindLast, junk);
  endtask

  // Random text seeded with whole and cut-short copies of the pattern
  task random_text(input int n, input bit close);
    int i;
    int cut;
    int plen;
    plen = eff_len();
    i = 0;
    while (i < n) begin
      if ($urandom_range(0, 4) == 0) begin
        cut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, plen) : plen;
        for (int k = 0; k < cut && i < n; k++) begin
          push_byte(pat_now[k], close && i == n - 1);
          i++;
        end
      end else begin
        push_byte($urandom_range(0, 1) ? pat_now[$urandom_range(0, plen - 1)]
                                       : 8'($urandom_range(0, 255)),
                  close && i == n - 1);
        i++;
      end
    end
  endtask

  // Long text with the pattern planted at a chosen start and again at the very end
  task long_text(input int n, input int at);
    int plen;
    logic [7:0] b;
    plen = eff_len();
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i >= at && i < at + plen) b = pat_now[i - at];
      if (i >= n - plen) b = pat_now[i - (n - plen)];
      push_byte(b, i == n - 1);
    end
  endtask

  initial begin
    int random_start;
    int texts;
    int n;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [LenW-1:0] len;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: one zero byte as the pattern, first mode
    push_byte(8'h00, 1'b1);
    settle();

    // Length zero counts as one; last mode over a byte of all ones
    set_pattern({8{8'hFF}}, {8{8'hFF}}, '0, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();

    // Over-long length saturates to the full window; then a text too short for it
    set_pattern({$urandom(), $urandom()}, {$urandom(), $urandom()}, '1, 1'b0);
    for (int i = 0; i < PatternMax; i++) push_byte(pat_now[i], i == PatternMax - 1);
    push_byte(pat_now[0], 1'b0);
    push_byte(pat_now[1], 1'b1);
    settle();

    // Switch from first to last mode half-way through a text
    set_pattern(64'h4241, 64'h0, LenW'(2), 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h42, 1'b0);
    settle();
    write_reg(CfgFindLast, 64'h1);
    push_byte(8'h41, 1'b0);
    push_byte(8'h42, 1'b1);
    settle();

    // Text limit: exactly at it, then just past it, without idling to keep the run short
    in_gap_max = 0;
    out_gap_max = 0;
    set_pattern({$urandom(), 24'h0, 8'h5A}, {$urandom(), $urandom()}, LenW'(1), 1'b1);
    long_text(int'(TextMax), int'(TextMax) - 1);
    settle();
    set_pattern({$urandom(), $urandom()}, {$urandom(), $urandom()}, LenW'(2), 1'b1);
    long_text(int'(TextMax) + 2, int'(TextMax) - 2);
    settle();

    // Random phases: fresh settings, a handful of texts, the odd text left open
    random_start = bytes_queued;
    while (bytes_queued - random_start < 1700) begin
      in_gap_max = $urandom_range(0, 1) ? 5 : 0;
      out_gap_max = $urandom_range(0, 1) ? 5 : 0;
      case ($urandom_range(0, 9))
        0: len = LenW'($urandom_range(0, 31));
        1: len = LenW'(PatternMax);
        default: len = LenW'($urandom_range(1, 5));
      endcase
      if ($urandom_range(0, 1)) begin
        lo = {$urandom(), $urandom()};
        hi = {$urandom(), $urandom()};
      end else begin
        // narrow alphabet so that near-misses and overlaps turn up
        for (int k = 0; k < 8; k++) begin
          lo[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 2));
          hi[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 2));
        end
      end
      set_pattern(lo, hi, len, 1'($urandom_range(0, 1)));
      texts = $urandom_range(2, 6);
      for (int t = 0; t < texts; t++) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        random_text(n, !(t == texts - 1 && $urandom_range(0, 5) == 0));
      end
      settle();
    end

    repeat (8) @(negedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ssfl_pkg.sv
design/ssfl_window_match.sv
design/substring_search_first_last_core.sv
sim/substring_search_first_last_core_test.sv
